FILE: hw/rtl/wdraw_pkg.sv
// ---------------------------------------------------------------------------
// wdraw_pkg
// shared codes, field widths and stream word layout of the weighted draw block
// ---------------------------------------------------------------------------
`default_nettype none

package wdraw_pkg;

  // field widths of the stream words
  localparam int IDX_W   = 6;
  localparam int WGT_W   = 16;
  localparam int FRAC_W  = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;

  // input tdata layout, lowest bit first
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_WGT_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_FRAC_LSB = IN_WGT_LSB + WGT_W;
  localparam int IN_TDATA_W  = ((IN_FRAC_LSB + FRAC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_DRAWN = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_LIMIT = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/wdraw_ram.sv
// ---------------------------------------------------------------------------
// wdraw_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module wdraw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_draw_without_replacement.sv
// ---------------------------------------------------------------------------
// weighted_draw_without_replacement
// weighted draw without replacement over a table of integer weights
// ---------------------------------------------------------------------------
// usage
//   in_* carries one word per item: in_tuser is the kind (load, start, draw),
//   in_tdata holds entry index, weight and a 32-bit random fraction
//   load writes one entry of the load table
//   start copies the load table into the working table at one read and one
//   write a cycle on the two weight rams
//   draw forms r = (u*total)>>32 with one 32x32 multiplier, low half of the
//   total, then high half, then the sum, then walks the working ram one entry
//   a cycle until the prefix sum passes r; a draw that hits the draw limit or
//   an empty table goes straight from idle to its result state
//   out_tdata is the chosen index, out_tuser the status
//   cfg_* writes draw_count at any time the block is idle, always ready
// reset
//   after rst_n both rams are swept to zero, one entry a cycle, so in_tready
//   stays low until the sweep ends; draw_count comes up as one
// stalls
//   the result sits in an output register; loads and starts are taken while
//   it waits, a further draw holds in its result state until the word leaves
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_draw_without_replacement #(
  parameter int ENTRIES     = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [5:0] entry_index, [21:6] weight, [53:22] random_fraction, rest zero
  input  wire logic [wdraw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  wire logic [wdraw_pkg::KIND_W-1:0]        in_tuser,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [5:0] chosen_index, rest zero
  output logic      [wdraw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic      [wdraw_pkg::STAT_W-1:0]        out_tuser,
  // configuration write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wdraw_pkg::CNT_W-1:0]         cfg_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam int TW = WEIGHT_BITS + AW;   // total never exceeds ENTRIES full weights
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD_RD, ST_LOAD_WR, ST_COPY,
    ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_SCAN, ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // sweep address and read pipeline tracking
  logic [AW-1:0]                  rd_addr_r, rd_addr_nxt;
  logic                           issue_r, issue_nxt;
  logic                           data_ok_r;
  logic [AW-1:0]                  data_idx_r;

  // datapath
  logic [WEIGHT_BITS-1:0]         ld_w_r, ld_w_nxt;
  logic [wdraw_pkg::FRAC_W-1:0]   u_r, u_nxt;
  logic [63:0]                    prod_r, prod_nxt;
  logic [TW-1:0]                  r_r, r_nxt;
  logic [TW-1:0]                  prefix_r, prefix_nxt;
  logic [TW-1:0]                  loaded_total_r, loaded_total_nxt;
  logic [TW-1:0]                  working_total_r, working_total_nxt;
  logic [wdraw_pkg::CNT_W-1:0]    draws_done_r, draws_done_nxt;
  logic [wdraw_pkg::CNT_W-1:0]    draw_count_r, draw_count_nxt;
  logic [wdraw_pkg::IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [wdraw_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [wdraw_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [wdraw_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;

  // ram ports
  logic                           lw_we, ww_we;
  logic [AW-1:0]                  lw_waddr, ww_waddr;
  logic [WEIGHT_BITS-1:0]         lw_wdata, ww_wdata;
  logic [WEIGHT_BITS-1:0]         lw_rdata, ww_rdata;

  // unpacked input word
  logic                           in_fire;
  logic [wdraw_pkg::KIND_W-1:0]   in_kind;
  logic [31:0]                    in_idx32;
  logic [31:0]                    in_w32;
  logic [AW-1:0]                  in_addr;
  logic                           in_idx_ok;
  logic [WEIGHT_BITS-1:0]         in_w;
  logic [wdraw_pkg::FRAC_W-1:0]   in_u;

  // scan helpers
  logic [TW-1:0]                  prefix_sum;
  logic                           scan_hit;
  logic [31:0]                    pick32;
  logic [63:0]                    tot64;
  logic [63:0]                    hi_part;
  logic [63:0]                    r_sum;

  // shared multiplier, low half of the total first, then the high half
  logic [31:0]                    mul_b;
  logic [63:0]                    mul_p;

  assign in_fire   = in_tvalid && in_tready;
  assign in_kind   = in_tuser;
  assign in_idx32  = 32'(in_tdata[wdraw_pkg::IN_IDX_LSB +: wdraw_pkg::IDX_W]);
  assign in_w32    = 32'(in_tdata[wdraw_pkg::IN_WGT_LSB +: wdraw_pkg::WGT_W]);
  assign in_u      = in_tdata[wdraw_pkg::IN_FRAC_LSB +: wdraw_pkg::FRAC_W];
  assign in_addr   = in_idx32[AW-1:0];
  assign in_idx_ok = in_idx32 < 32'(ENTRIES);
  // weights wider than the table are masked down
  assign in_w      = in_w32[WEIGHT_BITS-1:0];

  assign prefix_sum = prefix_r + TW'(ww_rdata);
  assign scan_hit   = (state_r == ST_SCAN) && data_ok_r && (prefix_sum > r_r);
  assign pick32     = 32'(data_idx_r);
  assign tot64      = 64'(working_total_r);
  assign hi_part    = 64'(prod_r[63:32]);
  assign r_sum      = 64'(r_r) + prod_r;

  assign mul_b      = (state_r == ST_MUL_HI) ? tot64[63:32] : tot64[31:0];
  assign mul_p      = 64'(u_r) * 64'(mul_b);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = wdraw_pkg::OUT_TDATA_W'(out_idx_r);
  assign out_tuser  = out_status_r;

  // load table
  wdraw_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ENTRIES)) u_loaded_ram (
    .clk   (clk),
    .we    (lw_we),
    .waddr (lw_waddr),
    .wdata (lw_wdata),
    .raddr (rd_addr_r),
    .rdata (lw_rdata)
  );

  // working table
  wdraw_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ENTRIES)) u_working_ram (
    .clk   (clk),
    .we    (ww_we),
    .waddr (ww_waddr),
    .wdata (ww_wdata),
    .raddr (rd_addr_r),
    .rdata (ww_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    rd_addr_nxt       = rd_addr_r;
    issue_nxt         = issue_r;
    ld_w_nxt          = ld_w_r;
    u_nxt             = u_r;
    prod_nxt          = prod_r;
    r_nxt             = r_r;
    prefix_nxt        = prefix_r;
    loaded_total_nxt  = loaded_total_r;
    working_total_nxt = working_total_r;
    draws_done_nxt    = draws_done_r;
    draw_count_nxt    = draw_count_r;
    res_idx_nxt       = res_idx_r;
    res_status_nxt    = res_status_r;
    out_tvalid_nxt    = out_tvalid_r && !out_tready;
    out_idx_nxt       = out_idx_r;
    out_status_nxt    = out_status_r;
    lw_we             = 1'b0;
    lw_waddr          = rd_addr_r;
    lw_wdata          = '0;
    ww_we             = 1'b0;
    ww_waddr          = data_idx_r;
    ww_wdata          = '0;

    if (cfg_valid) begin
      draw_count_nxt = cfg_data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // zero both tables, one entry a cycle
        lw_we    = 1'b1;
        ww_we    = 1'b1;
        ww_waddr = rd_addr_r;
        if (rd_addr_r == LAST) begin
          rd_addr_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            wdraw_pkg::KIND_LOAD: begin
              if (in_idx_ok) begin
                rd_addr_nxt = in_addr;
                ld_w_nxt    = in_w;
                state_nxt   = ST_LOAD_RD;
              end
            end
            wdraw_pkg::KIND_START: begin
              rd_addr_nxt       = '0;
              issue_nxt         = 1'b1;
              working_total_nxt = loaded_total_r;
              draws_done_nxt    = '0;
              state_nxt         = ST_COPY;
            end
            wdraw_pkg::KIND_DRAW: begin
              u_nxt       = in_u;
              res_idx_nxt = '0;
              if (draws_done_r >= draw_count_r) begin
                res_status_nxt = wdraw_pkg::STATUS_LIMIT;
                state_nxt      = ST_RESULT;
              end else if (working_total_r == '0) begin
                res_status_nxt = wdraw_pkg::STATUS_EMPTY;
                state_nxt      = ST_RESULT;
              end else begin
                state_nxt = ST_MUL_LO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD_RD: begin
        state_nxt = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        // old weight is on the read port now
        lw_we            = 1'b1;
        lw_wdata         = ld_w_r;
        loaded_total_nxt = loaded_total_r - TW'(lw_rdata) + TW'(ld_w_r);
        state_nxt        = ST_IDLE;
      end
      ST_COPY: begin
        ww_we    = data_ok_r;
        ww_wdata = lw_rdata;
        if (issue_r) begin
          if (rd_addr_r == LAST) begin
            issue_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
        if (data_ok_r && data_idx_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL_LO: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        r_nxt     = hi_part[TW-1:0];
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_SUM;
      end
      ST_MUL_SUM: begin
        r_nxt       = r_sum[TW-1:0];
        prefix_nxt  = '0;
        rd_addr_nxt = '0;
        issue_nxt   = 1'b1;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_r) begin
          if (rd_addr_r == LAST) begin
            issue_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
        if (data_ok_r) begin
          prefix_nxt = prefix_sum;
          if (scan_hit) begin
            // take the entry out of the working table
            ww_we             = 1'b1;
            working_total_nxt = working_total_r - TW'(ww_rdata);
            draws_done_nxt    = draws_done_r + 1'b1;
            res_idx_nxt       = pick32[wdraw_pkg::IDX_W-1:0];
            res_status_nxt    = wdraw_pkg::STATUS_DRAWN;
            issue_nxt         = 1'b0;
            state_nxt         = ST_RESULT;
          end else if (data_idx_r == LAST) begin
            res_idx_nxt    = '0;
            res_status_nxt = wdraw_pkg::STATUS_DRAWN;
            state_nxt      = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload
    data_idx_r   <= rd_addr_r;
    ld_w_r       <= ld_w_nxt;
    u_r          <= u_nxt;
    prod_r       <= prod_nxt;
    r_r          <= r_nxt;
    prefix_r     <= prefix_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      rd_addr_r       <= '0;
      issue_r         <= 1'b0;
      data_ok_r       <= 1'b0;
      loaded_total_r  <= '0;
      working_total_r <= '0;
      draws_done_r    <= '0;
      draw_count_r    <= wdraw_pkg::CNT_W'(1);
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      rd_addr_r       <= rd_addr_nxt;
      issue_r         <= issue_nxt;
      data_ok_r       <= issue_r;
      loaded_total_r  <= loaded_total_nxt;
      working_total_r <= working_total_nxt;
      draws_done_r    <= draws_done_nxt;
      draw_count_r    <= draw_count_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a picked entry always carries weight
  a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    scan_hit |-> (ww_rdata != '0))
    else $error("draw picked an entry of zero weight");

  // the walk always ends on a hit before running off the table
  a_scan_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && data_ok_r && data_idx_r == LAST) |-> scan_hit)
    else $error("prefix walk passed the last entry without a hit");

  // a successful draw takes its weight off the working total
  a_total_drops: assert property (@(posedge clk) disable iff (!rst_n)
    scan_hit |=> (working_total_r == $past(working_total_r) - TW'($past(ww_rdata))))
    else $error("working total not reduced by the drawn weight");

  // only a drawn status carries an index
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_status_r != wdraw_pkg::STATUS_DRAWN) |-> (out_idx_r == '0))
    else $error("index set on a result that drew nothing");
`endif

endmodule

`default_nettype wire

FILE: bench/wdraw_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wdraw_checker
// watches the stream ports of the weighted draw block, keeps its own copy of
// the weight tables, works out each draw result and compares it with the
// words that leave the block
// ---------------------------------------------------------------------------

module wdraw_checker #(
  parameter int ENTRIES     = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  input  wire logic                                in_tready,
  // [5:0] entry_index, [21:6] weight, [53:22] random_fraction, rest zero
  input  wire logic [wdraw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  wire logic [wdraw_pkg::KIND_W-1:0]        in_tuser,
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  // [5:0] chosen_index, rest zero
  input  wire logic [wdraw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  input  wire logic [wdraw_pkg::STAT_W-1:0]        out_tuser,
  input  wire logic                                cfg_valid,
  input  wire logic                                cfg_ready,
  input  wire logic [wdraw_pkg::CNT_W-1:0]         cfg_data,
  output int                                       fail_count,
  output int                                       pending_results
);

  localparam int SUM_W = $clog2(ENTRIES) + WEIGHT_BITS;

  typedef struct packed {
    logic [wdraw_pkg::IDX_W-1:0]  index;
    logic [wdraw_pkg::STAT_W-1:0] status;
  } draw_result_t;

  draw_result_t draw_results_q[$];

  logic [WEIGHT_BITS-1:0]       loaded_w  [ENTRIES];
  logic [WEIGHT_BITS-1:0]       working_w [ENTRIES];
  logic [SUM_W-1:0]             loaded_sum;
  logic [SUM_W-1:0]             working_sum;
  logic [wdraw_pkg::CNT_W-1:0]  draws_done;
  logic [wdraw_pkg::CNT_W-1:0]  draw_limit;

  // first entry whose running sum passes floor(frac * total / 2^32)
  function automatic int unsigned pick_entry(logic [wdraw_pkg::FRAC_W-1:0] frac);
    logic [63:0] scaled;
    logic [63:0] prefix;
    int unsigned pick;
    scaled = (64'(frac) * 64'(working_sum)) >> 32;
    prefix = '0;
    pick   = 0;
    for (int e = 0; e < ENTRIES; e++) begin
      prefix = prefix + 64'(working_w[e]);
      if (prefix > scaled) begin
        pick = e;
        break;
      end
    end
    return pick;
  endfunction

  task automatic track_word(logic [wdraw_pkg::KIND_W-1:0] kind,
                            logic [wdraw_pkg::IDX_W-1:0] idx,
                            logic [wdraw_pkg::WGT_W-1:0] wgt,
                            logic [wdraw_pkg::FRAC_W-1:0] frac);
    logic [WEIGHT_BITS-1:0] w;
    int unsigned pick;
    w = WEIGHT_BITS'(wgt);
    case (kind)
      wdraw_pkg::KIND_LOAD: begin
        if (idx < ENTRIES) begin
          loaded_sum    = loaded_sum - SUM_W'(loaded_w[idx]) + SUM_W'(w);
          loaded_w[idx] = w;
        end
      end
      wdraw_pkg::KIND_START: begin
        for (int e = 0; e < ENTRIES; e++) working_w[e] = loaded_w[e];
        working_sum = loaded_sum;
        draws_done  = '0;
      end
      wdraw_pkg::KIND_DRAW: begin
        // the count limit wins over an empty table
        if (draws_done >= draw_limit) begin
          draw_results_q.push_back('{index: '0, status: wdraw_pkg::STATUS_LIMIT});
        end else if (working_sum == '0) begin
          draw_results_q.push_back('{index: '0, status: wdraw_pkg::STATUS_EMPTY});
        end else begin
          pick = pick_entry(frac);
          working_sum     = working_sum - SUM_W'(working_w[pick]);
          working_w[pick] = '0;
          draws_done      = draws_done + 1'b1;
          draw_results_q.push_back('{index: wdraw_pkg::IDX_W'(pick),
                                     status: wdraw_pkg::STATUS_DRAWN});
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(logic [wdraw_pkg::OUT_TDATA_W-1:0] data,
                              logic [wdraw_pkg::STAT_W-1:0] stat);
    draw_result_t want;
    if (draw_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result word with none due: index %0d status %0d",
                 $realtime, data, stat);
    end else begin
      want = draw_results_q.pop_front();
      if (data !== wdraw_pkg::OUT_TDATA_W'(want.index) || stat !== want.status) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result mismatch: index %0d status %0d, wanted index %0d status %0d",
                   $realtime, data, stat, want.index, want.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) begin
        loaded_w[e]  = '0;
        working_w[e] = '0;
      end
      loaded_sum  = '0;
      working_sum = '0;
      draws_done  = '0;
      draw_limit  = wdraw_pkg::CNT_W'(1);
      draw_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tuser);
      if (cfg_valid && cfg_ready) draw_limit = cfg_data;
      if (in_tvalid && in_tready)
        track_word(in_tuser, in_tdata[wdraw_pkg::IN_IDX_LSB +: wdraw_pkg::IDX_W],
                   in_tdata[wdraw_pkg::IN_WGT_LSB +: wdraw_pkg::WGT_W],
                   in_tdata[wdraw_pkg::IN_FRAC_LSB +: wdraw_pkg::FRAC_W]);
    end
    pending_results = draw_results_q.size();
  end

endmodule

FILE: bench/tb_weighted_draw_without_replacement.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_weighted_draw_without_replacement
// drives load, start and draw words into the weighted draw block under random
// gaps and back-pressure, steps draw_count through its extremes, and lets the
// checker compare every result word with its own prediction
// ---------------------------------------------------------------------------

module tb_weighted_draw_without_replacement;

  localparam int ENTRIES         = 64;
  localparam int WEIGHT_BITS     = 16;
  // the one kind code the block has to ignore
  localparam logic [wdraw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  // a start walks the whole table, so the block may still be busy this long
  // after the last result word has left
  localparam int SETTLE_CYCLES   = ENTRIES + 16;
  // long receiver hold-off that fills the block and stalls its input
  localparam int HOLD_OFF_CYCLES = 400;
  // cycles without any accepted word before the run is given up
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_WORDS    = 850;
  localparam int PHASE_WORDS     = 120;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [wdraw_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic [wdraw_pkg::KIND_W-1:0]         in_tuser = wdraw_pkg::KIND_LOAD;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [wdraw_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic [wdraw_pkg::STAT_W-1:0]         out_tuser;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [wdraw_pkg::CNT_W-1:0]          cfg_data = '0;

  int fail_count;
  int pending_results;

  // words counted towards the random part, kind 3 not included
  int words_sent = 0;
  // draw_count as last written, used to size the rounds
  int draw_limit_now = 1;
  // stretches without idling, per side: 0 sender, 1 receiver
  int calm_left[2] = '{0, 0};
  int hold_requests = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  weighted_draw_without_replacement #(
    .ENTRIES     (ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  wdraw_checker #(
    .ENTRIES     (ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // mostly no gap or a short one, now and then a long one, and once in a
  // while a calm stretch with no gaps at all
  function automatic int idle_gap(int side);
    int roll;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // zero, full scale and tiny weights show up often next to plain random ones
  function automatic logic [wdraw_pkg::WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return wdraw_pkg::WGT_W'($urandom_range(1, 15));
      default: return wdraw_pkg::WGT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [wdraw_pkg::FRAC_W-1:0] pick_fraction();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // offer one word from a falling edge and return at the falling edge after
  // it was taken; the caller either offers the next word at once or lowers
  // in_tvalid in the same step
  task automatic push_word(logic [wdraw_pkg::KIND_W-1:0] kind,
                           logic [wdraw_pkg::IDX_W-1:0] idx,
                           logic [wdraw_pkg::WGT_W-1:0] wgt,
                           logic [wdraw_pkg::FRAC_W-1:0] frac);
    int gap;
    logic [wdraw_pkg::IN_TDATA_W-1:0] word;
    gap = idle_gap(0);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[wdraw_pkg::IN_IDX_LSB +: wdraw_pkg::IDX_W]   = idx;
    word[wdraw_pkg::IN_WGT_LSB +: wdraw_pkg::WGT_W]   = wgt;
    word[wdraw_pkg::IN_FRAC_LSB +: wdraw_pkg::FRAC_W] = frac;
    in_tdata  = word;
    in_tuser  = kind;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind != KIND_UNUSED) words_sent++;
  endtask

  // every result in, then let a start that is still copying finish
  task automatic settle_idle();
    in_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_draw_count(logic [wdraw_pkg::CNT_W-1:0] value);
    settle_idle();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    draw_limit_now = value;
  endtask

  // one sampling round: table updates, a start, then draws with the odd
  // stray load, ignored kind or restart mixed in
  task automatic run_round();
    int n_loads;
    int n_draws;
    int roll;
    if ($urandom_range(0, 5) == 0) begin
      // rewrite the whole table, mostly with zeros, for sparse draws
      for (int e = 0; e < ENTRIES; e++)
        push_word(wdraw_pkg::KIND_LOAD, wdraw_pkg::IDX_W'(e),
                  ($urandom_range(0, 3) == 0) ? pick_weight() : '0, $urandom());
    end else begin
      n_loads = $urandom_range(0, 10);
      repeat (n_loads)
        push_word(wdraw_pkg::KIND_LOAD, wdraw_pkg::IDX_W'($urandom_range(0, 63)),
                  pick_weight(), $urandom());
    end
    push_word(wdraw_pkg::KIND_START, wdraw_pkg::IDX_W'($urandom_range(0, 63)),
              wdraw_pkg::WGT_W'($urandom()), $urandom());
    // run past the count limit or the end of the weights now and then
    n_draws = $urandom_range(1, ((draw_limit_now > 70) ? 70 : draw_limit_now) + 3);
    repeat (n_draws) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)
        push_word(wdraw_pkg::KIND_LOAD, wdraw_pkg::IDX_W'($urandom_range(0, 63)),
                  pick_weight(), $urandom());
      else if (roll < 9)
        push_word(KIND_UNUSED, wdraw_pkg::IDX_W'($urandom()),
                  wdraw_pkg::WGT_W'($urandom()), $urandom());
      else if (roll < 10)
        push_word(wdraw_pkg::KIND_START, wdraw_pkg::IDX_W'($urandom()),
                  wdraw_pkg::WGT_W'($urandom()), $urandom());
      push_word(wdraw_pkg::KIND_DRAW, wdraw_pkg::IDX_W'($urandom()),
                wdraw_pkg::WGT_W'($urandom()), pick_fraction());
    end
  endtask

  function automatic logic [wdraw_pkg::CNT_W-1:0] phase_limit(int phase);
    case (phase)
      0:       return wdraw_pkg::CNT_W'(64);
      1:       return wdraw_pkg::CNT_W'(2);
      2:       return '1;
      3:       return wdraw_pkg::CNT_W'(1);
      4:       return '0;
      5:       return wdraw_pkg::CNT_W'(3);
      default: return wdraw_pkg::CNT_W'($urandom_range(0, 127));
    endcase
  endfunction

  // receiver: random stalls, plus the long hold-off when asked for
  initial begin : result_sink
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        stall_left = idle_gap(1);
        out_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // cycles with no word taken on any channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_first;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // draw_count still at its reset value of one
    // draws before any start and after a start of an empty table
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '0);
    push_word(wdraw_pkg::KIND_START, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '1, '1, '1);
    // extreme entries and weights, a zero weight, an ignored kind
    push_word(wdraw_pkg::KIND_LOAD, '0, '1, '0);
    push_word(wdraw_pkg::KIND_LOAD, '1, '1, '1);
    push_word(wdraw_pkg::KIND_LOAD, wdraw_pkg::IDX_W'(17), wdraw_pkg::WGT_W'(1), '0);
    push_word(wdraw_pkg::KIND_LOAD, wdraw_pkg::IDX_W'(40), '0, '1);
    push_word(KIND_UNUSED, '1, '1, '1);
    push_word(wdraw_pkg::KIND_START, '0, '0, '0);
    // lowest fraction picks the first entry, then the count limit of one
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '1);
    // load in the middle of a round, taken into the working table by the next start
    push_word(wdraw_pkg::KIND_LOAD, '0, '0, '0);
    push_word(wdraw_pkg::KIND_START, '0, '0, '0);
    // highest fraction lands on the last entry
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '1);

    // a limit of zero blocks every draw
    write_draw_count('0);
    push_word(wdraw_pkg::KIND_START, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, 32'h8000_0000);

    // limit above the table size: draw until the weights run out
    write_draw_count('1);
    push_word(wdraw_pkg::KIND_START, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, '0);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, 32'h5555_5555);
    push_word(wdraw_pkg::KIND_DRAW, '0, '0, 32'hAAAA_AAAA);

    // random rounds, phase by phase through the draw_count settings
    words_sent = 0;
    phase      = 0;
    while (words_sent < RANDOM_WORDS) begin
      write_draw_count(phase_limit(phase));
      if (phase == 1) hold_requests++;
      phase_first = words_sent;
      while (words_sent - phase_first < PHASE_WORDS && words_sent < RANDOM_WORDS)
        run_round();
      phase++;
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
